/* sv/stq_pkg.sv */
// Shared types, codes and helpers of the sorted timer queue.
package stq_pkg;

    localparam int OP_W      = 2;
    localparam int REM_W     = 32;
    localparam int KIND_W    = 2;
    localparam int OWNER_W   = 32;
    localparam int ELAPSED_W = 16;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_QUANTUM = 2'd2;

    localparam logic [KIND_W-1:0] KIND_TASK_SWITCH = 2'd2;

    typedef struct packed {
        logic signed [REM_W-1:0] remaining;
        logic [KIND_W-1:0]       kind;
        logic [OWNER_W-1:0]      owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // remaining - elapsed, clamped at the most negative value
    function automatic logic signed [REM_W-1:0] sat_sub(
        input logic signed [REM_W-1:0] a,
        input logic [ELAPSED_W-1:0]    b
    );
        logic [REM_W:0] d;
        d = {a[REM_W-1], a} - {{(REM_W+1-ELAPSED_W){1'b0}}, b};
        if (d[REM_W] != d[REM_W-1]) begin
            sat_sub = {1'b1, {(REM_W-1){1'b0}}};
        end else begin
            sat_sub = d[REM_W-1:0];
        end
    endfunction

endpackage

/* sv/stq_if.sv */
// Handshake interfaces for the command and result channels.
interface stq_in_if;
    logic                               valid;
    logic                               ready;
    logic [stq_pkg::OP_W-1:0]           op;
    logic signed [stq_pkg::REM_W-1:0]   delay;
    logic [stq_pkg::KIND_W-1:0]         kind;
    logic [stq_pkg::OWNER_W-1:0]        owner_id;
    logic [stq_pkg::ELAPSED_W-1:0]      elapsed;

    modport source (output valid, op, delay, kind, owner_id, elapsed, input ready);
    modport sink   (input valid, op, delay, kind, owner_id, elapsed, output ready);
endinterface

interface stq_out_if #(parameter int CNT_W = 5);
    logic                               valid;
    logic                               ready;
    logic                               head_valid;
    logic signed [stq_pkg::REM_W-1:0]   head_remaining;
    logic [stq_pkg::KIND_W-1:0]         head_kind;
    logic [stq_pkg::OWNER_W-1:0]        head_owner;
    logic [CNT_W-1:0]                   timer_count;
    logic                               dropped;

    modport source (output valid, head_valid, head_remaining, head_kind, head_owner,
                    timer_count, dropped, input ready);
    modport sink   (input valid, head_valid, head_remaining, head_kind, head_owner,
                    timer_count, dropped, output ready);
endinterface

/* sv/stq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stq_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/sorted_timer_queue.sv */
// Top level: sorted timer table walked by a small sequencer over one RAM.
//
// Usage:
//   i_in carries one command per beat: insert a timer, tick (subtract elapsed
//   from every timer, clamped at the most negative count) or quantum reset
//   (drop all task-switch timers, compact, insert one new task-switch timer).
//   o_out returns one result beat per command: head timer, count, dropped.
//   The table lives in a single RAM with one read and one write port; every
//   walk reads an entry, then writes it in the following cycle.
// Work per command, N = timers stored:
//   insert       walks back over the entries that move back (at most N),
//                stops at the first one not larger; dropped at once when full
//   tick         walks all N entries
//   quantum      compaction walk over all N, then an insert on the survivors
//   every walk is paced by the RAM port.
// i_in.ready is high only while the sequencer is idle; one command at a time.
// The result sits in an output register, so a new command is taken while
// the previous result still waits; a stalled o_out holds the sequencer in
// its last step until the result register frees up.
// Reset empties the table (count only, no clearing pass) and drops any result.
module sorted_timer_queue #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stq_in_if.sink    i_in,
    stq_out_if.source o_out
);

    localparam int AW    = $clog2(TIMER_SLOTS);
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_INS_GO  = 4'd2;
    localparam logic [3:0] S_INS_RD  = 4'd3;
    localparam logic [3:0] S_INS_WR  = 4'd4;
    localparam logic [3:0] S_INS_PUT = 4'd5;
    localparam logic [3:0] S_CMP_RD  = 4'd6;
    localparam logic [3:0] S_CMP_WR  = 4'd7;
    localparam logic [3:0] S_TICK_RD = 4'd8;
    localparam logic [3:0] S_TICK_WR = 4'd9;
    localparam logic [3:0] S_HEAD_RD = 4'd10;
    localparam logic [3:0] S_HEAD_WR = 4'd11;

    // control
    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic             r_dropped, n_dropped;
    logic             r_out_valid, n_out_valid;

    // captured command
    logic [stq_pkg::OP_W-1:0]         r_op, n_op;
    logic signed [stq_pkg::REM_W-1:0] r_delay, n_delay;
    logic [stq_pkg::KIND_W-1:0]       r_kind, n_kind;
    logic [stq_pkg::OWNER_W-1:0]      r_owner, n_owner;
    logic [stq_pkg::ELAPSED_W-1:0]    r_elapsed, n_elapsed;

    // result
    logic                             r_head_valid, n_head_valid;
    logic signed [stq_pkg::REM_W-1:0] r_head_rem, n_head_rem;
    logic [stq_pkg::KIND_W-1:0]       r_head_kind, n_head_kind;
    logic [stq_pkg::OWNER_W-1:0]      r_head_owner, n_head_owner;
    logic [CNT_W-1:0]                 r_res_count, n_res_count;
    logic                             r_res_dropped, n_res_dropped;

    // RAM port
    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    stq_pkg::t_entry              ram_wdata, ram_rdata, new_entry;
    logic [stq_pkg::ENTRY_W-1:0]  ram_rdata_raw;

    logic [CNT_W-1:0] idx_m1, idx_p1, wr_next;
    logic             keep;

    stq_ram #(
        .WIDTH (stq_pkg::ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = ram_rdata_raw;
    assign new_entry = '{remaining: r_delay, kind: r_kind, owner: r_owner};
    assign idx_m1    = r_idx - 1'b1;
    assign idx_p1    = r_idx + 1'b1;
    assign keep      = (ram_rdata.kind != stq_pkg::KIND_TASK_SWITCH);
    assign wr_next   = r_wr + CNT_W'(keep);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_wr          = r_wr;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_op          = r_op;
        n_delay       = r_delay;
        n_kind        = r_kind;
        n_owner       = r_owner;
        n_elapsed     = r_elapsed;
        n_head_valid  = r_head_valid;
        n_head_rem    = r_head_rem;
        n_head_kind   = r_head_kind;
        n_head_owner  = r_head_owner;
        n_res_count   = r_res_count;
        n_res_dropped = r_res_dropped;
        ram_we        = 1'b0;
        ram_waddr     = r_idx[AW-1:0];
        ram_wdata     = new_entry;
        ram_re        = 1'b0;
        ram_raddr     = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op      = i_in.op;
                    n_delay   = i_in.delay;
                    n_kind    = i_in.kind;
                    n_owner   = i_in.owner_id;
                    n_elapsed = i_in.elapsed;
                    n_dropped = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_idx = '0;
                n_wr  = '0;
                unique case (r_op)
                    stq_pkg::OP_INSERT: n_state = S_INS_GO;
                    stq_pkg::OP_TICK:
                        n_state = (r_count == '0) ? S_HEAD_RD : S_TICK_RD;
                    stq_pkg::OP_QUANTUM: begin
                        n_kind  = stq_pkg::KIND_TASK_SWITCH;
                        n_state = (r_count == '0) ? S_INS_GO : S_CMP_RD;
                    end
                    default: n_state = S_HEAD_RD;
                endcase
            end
            S_INS_GO: begin
                priority if (r_count == CNT_W'(TIMER_SLOTS)) begin
                    n_dropped = 1'b1;
                    n_state   = S_HEAD_RD;
                end else if (r_count == '0) begin
                    n_idx   = '0;
                    n_state = S_INS_PUT;
                end else begin
                    n_idx   = r_count;
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                ram_re    = 1'b1;
                ram_raddr = idx_m1[AW-1:0];
                n_state   = S_INS_WR;
            end
            S_INS_WR: begin
                // walk backward: move larger entries up one slot, stop at the first
                // entry not larger than the new one (keeps arrival order on ties)
                ram_we = 1'b1;
                if (ram_rdata.remaining > r_delay) begin
                    ram_wdata = ram_rdata;
                    n_idx     = idx_m1;
                    n_state   = (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_HEAD_RD;
                end
            end
            S_INS_PUT: begin
                ram_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_HEAD_RD;
            end
            S_CMP_RD: begin
                ram_re  = 1'b1;
                n_state = S_CMP_WR;
            end
            S_CMP_WR: begin
                ram_we    = keep;
                ram_waddr = r_wr[AW-1:0];
                ram_wdata = ram_rdata;
                n_wr      = wr_next;
                n_idx     = idx_p1;
                if (idx_p1 == r_count) begin
                    n_count = wr_next;
                    n_state = S_INS_GO;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_TICK_RD: begin
                ram_re  = 1'b1;
                n_state = S_TICK_WR;
            end
            S_TICK_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_wdata.remaining = stq_pkg::sat_sub(ram_rdata.remaining, r_elapsed);
                n_idx     = idx_p1;
                n_state   = (idx_p1 == r_count) ? S_HEAD_RD : S_TICK_RD;
            end
            S_HEAD_RD: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_state   = S_HEAD_WR;
            end
            S_HEAD_WR: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_head_valid  = (r_count != '0);
                    n_head_rem    = (r_count != '0) ? ram_rdata.remaining : '0;
                    n_head_kind   = (r_count != '0) ? ram_rdata.kind : '0;
                    n_head_owner  = (r_count != '0) ? ram_rdata.owner : '0;
                    n_res_count   = r_count;
                    n_res_dropped = r_dropped;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_wr        <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_wr        <= n_wr;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_delay       <= n_delay;
        r_kind        <= n_kind;
        r_owner       <= n_owner;
        r_elapsed     <= n_elapsed;
        r_head_valid  <= n_head_valid;
        r_head_rem    <= n_head_rem;
        r_head_kind   <= n_head_kind;
        r_head_owner  <= n_head_owner;
        r_res_count   <= n_res_count;
        r_res_dropped <= n_res_dropped;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.head_valid     = r_head_valid;
    assign o_out.head_remaining = r_head_rem;
    assign o_out.head_kind      = r_head_kind;
    assign o_out.head_owner     = r_head_owner;
    assign o_out.timer_count    = r_res_count;
    assign o_out.dropped        = r_res_dropped;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TIMER_SLOTS))
        else $error("timer count above table size");

    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write in the same cycle");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.head_valid == (o_out.timer_count != '0)))
        else $error("head valid disagrees with count");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.dropped) |-> (o_out.timer_count == CNT_W'(TIMER_SLOTS)))
        else $error("dropped beat with room in the table");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second command taken while busy");
`endif

endmodule
